/* hw/rtl/multicast_tree_load_evaluator_assert.svh */
// assertion macros for the multicast tree load evaluator
`ifndef MULTICAST_TREE_LOAD_EVALUATOR_ASSERT_SVH
`define MULTICAST_TREE_LOAD_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define MTLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtle assertion failed");

// next-cycle implication
`define MTLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtle assertion failed");

`endif

/* hw/rtl/mtle_pkg.sv */
package mtle_pkg;

  localparam int unsigned TreeW    = 6;
  localparam int unsigned EdgeW    = 12;
  localparam int unsigned CostW    = 16;
  localparam int unsigned CapW     = 16;
  localparam int unsigned HopsW    = 8;
  localparam int unsigned SumW     = 32;
  localparam int unsigned ResW     = 24;
  localparam int unsigned NegW     = 25;
  localparam int unsigned OwnerW   = 7;
  localparam int unsigned MaxEdges = 4096;
  localparam int unsigned WordW    = OwnerW + ResW;

  localparam int unsigned InFieldsW  = TreeW + EdgeW + CostW + 2 * CapW + HopsW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = TreeW + SumW + NegW + SumW + HopsW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [OwnerW-1:0] OwnerFree = '1;
  localparam logic [ResW-1:0]   ResMax    = {1'b0, {(ResW-1){1'b1}}};
  localparam logic [ResW-1:0]   ResMin    = {1'b1, {(ResW-1){1'b0}}};
  localparam logic [SumW-1:0]   SumMax    = '1;

  // packed lowest field last
  typedef struct packed {
    logic [HopsW-1:0] path_hops;
    logic [CapW-1:0]  tree_demand;
    logic [CapW-1:0]  edge_capacity;
    logic [CostW-1:0] edge_cost;
    logic [EdgeW-1:0] edge_index;
    logic [TreeW-1:0] tree_index;
  } in_item_t;

  typedef struct packed {
    logic [HopsW-1:0]       longest_path;
    logic [SumW-1:0]        total_cost_sum;
    logic signed [NegW-1:0] neg_min_residual;
    logic [SumW-1:0]        tree_cost_sum;
    logic [TreeW-1:0]       finished_tree;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             commit;
    logic             clear;
    logic [EdgeW-1:0] clr_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_pend;
    logic ind_end;
    logic out_stall;
  } dp_status_t;

endpackage

/* hw/rtl/mtle_ram.sv */
module mtle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mtle_ctrl.sv */
module mtle_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  mtle_pkg::dp_status_t  status_i,
  output mtle_pkg::ctrl_cmd_t   cmd_o
);
  import mtle_pkg::*;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } state_e;

  state_e           state_q, state_d;
  logic             ready_q;
  logic [EdgeW-1:0] clr_q, clr_d;
  logic             commit;

  assign commit = (state_q == StExec) && !(status_i.res_pend && status_i.out_stall);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == EdgeW'(MaxEdges - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (commit) begin
          state_d = status_i.ind_end ? StClear : StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ready_q <= (state_d == StIdle);
    end
  end

  assign s_axis_tready  = ready_q;
  assign cmd_o.load     = s_axis_tvalid && ready_q;
  assign cmd_o.commit   = commit;
  assign cmd_o.clear    = (state_q == StClear);
  assign cmd_o.clr_addr = clr_q;

endmodule

/* hw/rtl/mtle_dp.sv */
module mtle_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtle_pkg::in_item_t   item_i,
  input  logic                 tree_done_i,
  input  logic                 ind_done_i,
  input  mtle_pkg::ctrl_cmd_t  cmd_i,
  output mtle_pkg::dp_status_t status_o,
  output mtle_pkg::out_item_t  out_item_o,
  output logic                 out_final_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);
  import mtle_pkg::*;

  in_item_t         item_q;
  logic             tdone_q, idone_q;

  logic [SumW-1:0]  tree_cost_q, tree_cost_d;
  logic [SumW-1:0]  total_cost_q, total_cost_d;
  logic [ResW-1:0]  least_q, least_d;
  logic [HopsW-1:0] hops_q, hops_d;

  logic             out_valid_q;
  out_item_t        out_q;
  logic             out_final_q;

  logic             we;
  logic [EdgeW-1:0] waddr, raddr;
  logic [WordW-1:0] wdata, rdata;

  logic [OwnerW-1:0] owner_rd;
  logic [ResW-1:0]   res_rd;
  logic              new_edge;
  logic [SumW:0]     tree_sum, total_sum;
  logic [NegW-1:0]   sub_res;
  logic [ResW-1:0]   res_new;
  logic              res_pend;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q  <= item_i;
      tdone_q <= tree_done_i;
      idone_q <= ind_done_i;
    end
  end

  assign raddr = cmd_i.load ? item_i.edge_index : item_q.edge_index;
  assign waddr = cmd_i.clear ? cmd_i.clr_addr : item_q.edge_index;
  assign we    = cmd_i.clear || (cmd_i.commit && new_edge);
  assign wdata = cmd_i.clear ? {OwnerFree, {ResW{1'b0}}} : {1'b0, item_q.tree_index, res_new};

  mtle_ram #(
    .Width (WordW),
    .Depth (MaxEdges)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign owner_rd = rdata[WordW-1:ResW];
  assign res_rd   = rdata[ResW-1:0];
  assign new_edge = (owner_rd != {1'b0, item_q.tree_index});
  assign res_pend = tdone_q || idone_q;

  // residual update with floor
  assign sub_res = {res_rd[ResW-1], res_rd} - {{(NegW-CapW){1'b0}}, item_q.tree_demand};

  always_comb begin
    if (owner_rd == OwnerFree) begin
      res_new = {{(ResW-CapW){1'b0}}, item_q.edge_capacity}
              - {{(ResW-CapW){1'b0}}, item_q.tree_demand};
    end else if (sub_res[NegW-1] != sub_res[NegW-2]) begin
      res_new = ResMin;
    end else begin
      res_new = sub_res[ResW-1:0];
    end
  end

  assign tree_sum  = {1'b0, tree_cost_q} + {{(SumW-CostW+1){1'b0}}, item_q.edge_cost};
  assign total_sum = {1'b0, total_cost_q} + {{(SumW-CostW+1){1'b0}}, item_q.edge_cost};

  always_comb begin
    tree_cost_d  = tree_cost_q;
    total_cost_d = total_cost_q;
    least_d      = least_q;
    hops_d       = (item_q.path_hops > hops_q) ? item_q.path_hops : hops_q;
    if (new_edge) begin
      tree_cost_d  = tree_sum[SumW] ? SumMax : tree_sum[SumW-1:0];
      total_cost_d = total_sum[SumW] ? SumMax : total_sum[SumW-1:0];
      if ($signed(res_new) < $signed(least_q)) begin
        least_d = res_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_cost_q  <= '0;
      total_cost_q <= '0;
      least_q      <= ResMax;
      hops_q       <= '0;
    end else if (cmd_i.commit) begin
      if (idone_q) begin
        tree_cost_q  <= '0;
        total_cost_q <= '0;
        least_q      <= ResMax;
        hops_q       <= '0;
      end else begin
        tree_cost_q  <= tdone_q ? '0 : tree_cost_d;
        total_cost_q <= total_cost_d;
        least_q      <= least_d;
        hops_q       <= hops_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && res_pend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && res_pend) begin
      out_q.finished_tree <= item_q.tree_index;
      out_q.tree_cost_sum <= tree_cost_d;
      out_final_q         <= idone_q;
      if (idone_q) begin
        out_q.neg_min_residual <= NegW'(0) - {least_d[ResW-1], least_d};
        out_q.total_cost_sum   <= total_cost_d;
        out_q.longest_path     <= hops_d;
      end else begin
        out_q.neg_min_residual <= '0;
        out_q.total_cost_sum   <= '0;
        out_q.longest_path     <= '0;
      end
    end
  end

  assign status_o.res_pend  = res_pend;
  assign status_o.ind_end   = idone_q;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  assign out_item_o  = out_q;
  assign out_final_o = out_final_q;
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/multicast_tree_load_evaluator.sv */
// channel    dir  tdata (low bit up)                                tlast      tuser
// s_axis     in   tree_index, edge_index, edge_cost, edge_capacity,  tree_done  individual_done
//                 tree_demand, path_hops, zero fill to 80 bits
// m_axis     out  finished_tree, tree_cost_sum, neg_min_residual,    -          final_flag
//                 total_cost_sum, longest_path, zero fill to 104 bits
//
// each request is accepted with an edge table read, then committed by read-modify-write;
// tready stays low until the commit, as the single edge table ram has a registered read
// after reset the edge table is swept clear over all 4096 entries with tready low, and the
// same sweep follows every request that carries individual_done
// a request that ends a tree or an individual holds in commit while the output register is full and not taken
module multicast_tree_load_evaluator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tree_index, edge_index, edge_cost, edge_capacity, tree_demand, path_hops
  input  logic [mtle_pkg::InDataW-1:0]     s_axis_tdata,
  // tree_done
  input  logic                             s_axis_tlast,
  // individual_done
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // finished_tree, tree_cost_sum, neg_min_residual, total_cost_sum, longest_path
  output logic [mtle_pkg::OutDataW-1:0]    m_axis_tdata,
  // final_flag
  output logic                             m_axis_tuser
);
  import mtle_pkg::*;

  `include "multicast_tree_load_evaluator_assert.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;
  in_item_t   item;
  out_item_t  out_item;

  assign item = s_axis_tdata[InFieldsW-1:0];

  mtle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  mtle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .tree_done_i (s_axis_tlast),
    .ind_done_i  (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item),
    .out_final_o (m_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OutDataW-OutFieldsW){1'b0}}, out_item};

  `MTLE_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !s_axis_tready)
  `MTLE_ASSERT_NOW(a_no_load_on_commit, cmd.commit, !cmd.load)
  `MTLE_ASSERT_NEXT(a_clear_after_ind_end, cmd.commit && status.ind_end, cmd.clear)
  `MTLE_ASSERT_NEXT(a_result_after_commit, cmd.commit && status.res_pend, m_axis_tvalid)

endmodule
